>>> rtl/core/dep_queue_pkg.sv
package dep_queue_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_DEL_MAX = 2'd1;
    localparam logic [1:0] OP_DEL_MIN = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] max_value;
        logic signed [VAL_W-1:0] min_value;
        logic [6:0]              stored_count;
        logic [1:0]              status;
    } t_out_item;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                    ins;
        logic                    del_min;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

>>> rtl/core/dep_queue_cell.sv
module dep_queue_cell
    import dep_queue_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic                    i_occ,
    input  logic                    i_lo_occ,
    input  logic                    i_lo_gt,
    input  logic signed [VAL_W-1:0] i_lo_val,
    input  logic signed [VAL_W-1:0] i_hi_val,
    output logic signed [VAL_W-1:0] o_val,
    output logic                    o_gt
);

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;

    // new value sorts in front of this entry
    assign o_gt  = i_occ && (i_ctl.value < r_val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (i_lo_gt) begin
                n_val = i_lo_val;
            end else if (o_gt || (!i_occ && i_lo_occ)) begin
                n_val = i_ctl.value;
            end
        end else if (i_ctl.del_min) begin
            n_val = i_hi_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> rtl/core/double_ended_priority_queue.sv
// double-ended priority queue over a sorted row of cells
//
// input channel (i_in_valid / o_in_stall / i_in_data): one command per
// transfer, insert a value, delete the maximum or delete the minimum
// output channel (o_out_valid / i_out_stall / o_out_data): exactly one
// result per command with the max, min, count and a status code
//
// every cell holds one entry in ascending order; an insert compares the
// new value against all cells at once and the larger entries move up one
// cell, a delete of the minimum moves every entry down one cell, and a
// delete of the maximum only lowers the count
//
// the cells update at the input transfer edge and the result register
// loads from the pending command once the output slot is free; one
// command per cycle is sustained while the output is taken
//
// a stalled result holds in the output register; one further command
// may be accepted and waits as pending, then the input stalls too
// reset empties the queue and drops any pending or held result
module double_ended_priority_queue
    import dep_queue_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_pend;
    logic             n_pend;
    logic [1:0]       r_pend_status;
    logic [1:0]       n_pend_status;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             in_xfer;
    logic             out_load;
    logic             full;
    logic             empty;
    t_cell_ctl        ctl;

    logic signed [VAL_W-1:0] cell_val [CAPACITY];
    logic                    cell_gt  [CAPACITY];
    logic                    cell_occ [CAPACITY];

    // result register loads when pending and the slot frees up this cycle
    assign out_load   = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !out_load;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign full  = (r_count >= CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        ctl.value   = i_in_data.value;
        ctl.ins     = in_xfer && (i_in_data.operation == OP_INSERT) && !full;
        ctl.del_min = in_xfer && (i_in_data.operation == OP_DEL_MIN) && !empty;
    end

    // count and status of the accepted command
    always_comb begin
        n_count       = r_count;
        n_pend_status = r_pend_status;
        if (in_xfer) begin
            n_pend_status = ST_DONE;
            case (i_in_data.operation)
                OP_INSERT: begin
                    if (full) begin
                        n_pend_status = ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                OP_DEL_MAX, OP_DEL_MIN: begin
                    if (empty) begin
                        n_pend_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                    n_pend_status = ST_DONE;
                end
            endcase
        end
    end

    // the cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign cell_occ[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_first
            dep_queue_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (ctl),
                .i_occ    (cell_occ[g]),
                .i_lo_occ (1'b1),
                .i_lo_gt  (1'b0),
                .i_lo_val ('0),
                .i_hi_val (cell_val[(g + 1) % CAPACITY]),
                .o_val    (cell_val[g]),
                .o_gt     (cell_gt[g])
            );
        end else if (g == CAPACITY - 1) begin : g_last
            // top cell has no upper neighbor; it keeps its own entry
            dep_queue_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (ctl),
                .i_occ    (cell_occ[g]),
                .i_lo_occ (cell_occ[g - 1]),
                .i_lo_gt  (cell_gt[g - 1]),
                .i_lo_val (cell_val[g - 1]),
                .i_hi_val (cell_val[g]),
                .o_val    (cell_val[g]),
                .o_gt     (cell_gt[g])
            );
        end else begin : g_mid
            dep_queue_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (ctl),
                .i_occ    (cell_occ[g]),
                .i_lo_occ (cell_occ[g - 1]),
                .i_lo_gt  (cell_gt[g - 1]),
                .i_lo_val (cell_val[g - 1]),
                .i_hi_val (cell_val[g + 1]),
                .o_val    (cell_val[g]),
                .o_gt     (cell_gt[g])
            );
        end
    end

    // result from the updated row: the topmost occupied cell is the max
    always_comb begin
        n_out.max_value    = '0;
        n_out.min_value    = empty ? '0 : cell_val[0];
        n_out.stored_count = 7'(r_count);
        n_out.status       = r_pend_status;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_occ[i] && ((i == CAPACITY - 1) || !cell_occ[(i + 1) % CAPACITY])) begin
                n_out.max_value = n_out.max_value | cell_val[i];
            end
        end
    end

    always_comb begin
        n_pend      = in_xfer || (r_pend && !out_load);
        n_out_valid = out_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
